@@ src/json_key_value_extractor_defines.svh @@
// Assertion helpers for the key/value extractor.
`ifndef JSON_KEY_VALUE_EXTRACTOR_DEFINES_SVH
`define JSON_KEY_VALUE_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define JKV_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("jkv assertion failed");

// Next-cycle implication, also active during reset.
`define JKV_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("jkv assertion failed");

`endif

@@ src/jkv_pkg.sv @@
package jkv_pkg;

  localparam int KEY_MAX_DEF = 16;
  localparam int QDEPTH      = 2;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW    = 3'd1;
  localparam logic [2:0] REG_KEY_HIGH   = 3'd2;
  localparam logic [2:0] REG_MODE       = 3'd3;
  localparam logic [2:0] REG_CAPACITY   = 3'd4;

  localparam logic [4:0]  KEY_LENGTH_RST = 5'd1;
  localparam logic [15:0] CAPACITY_RST   = 16'd256;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // classified input byte, front to back
  typedef struct packed {
    logic       le;
    logic [7:0] c;
    logic       eq;      // window equals quoted key pattern
    logic       sp;
    logic       q;
    logic       colon;
    logic       bs;
    logic       is_t;
    logic       is_f;
    logic       is_u;
    logic [7:0] esc_d;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       found;
    logic       bval;
    logic       last;
  } res_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] limit;
  } bk_cfg_t;

endpackage

@@ src/jkv_front.sv @@
module jkv_front #(
  parameter int KEY_MAX = jkv_pkg::KEY_MAX_DEF,
  localparam int KLW = $clog2(KEY_MAX + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            line_end,
  input  logic [KLW-1:0]  klen,
  input  logic [63:0]     key_lo,
  input  logic [63:0]     key_hi,
  output jkv_pkg::item_t  item
);

  localparam int WIN = KEY_MAX + 2;

  logic [7:0]     win_r   [WIN];
  logic [7:0]     win_nxt [WIN];
  logic [7:0]     key_arr [KEY_MAX];
  logic [7:0]     pat     [WIN];
  logic [WIN-1:0] tap_ok;

  for (genvar k = 0; k < KEY_MAX; k++) begin : g_key
    if (k < 8) begin : g_lo
      assign key_arr[k] = key_lo[8*k +: 8];
    end else if (k < 16) begin : g_hi
      assign key_arr[k] = key_hi[8*(k-8) +: 8];
    end else begin : g_zero
      assign key_arr[k] = 8'h00;
    end
  end

  // pattern byte seen at tap i: closing quote at tap 0, key reversed, opening quote at klen+1
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      pat[i] = 8'h00;
      for (int k = 0; k < KEY_MAX; k++) begin
        if (int'(klen) == i + k) begin
          pat[i] = key_arr[k];
        end
      end
      if (i == 0 || i == int'(klen) + 1) begin
        pat[i] = jkv_pkg::CH_QUOTE;
      end
    end
  end

  always_comb begin
    win_nxt[0] = in_byte;
    for (int i = 1; i < WIN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    for (int i = 0; i < WIN; i++) begin
      tap_ok[i] = (i > int'(klen) + 1) || (win_nxt[i] == pat[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && line_end)) begin
      for (int i = 0; i < WIN; i++) begin
        win_r[i] <= 8'h00;
      end
    end else if (accept) begin
      for (int i = 0; i < WIN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_comb begin
    item.le    = line_end;
    item.c     = in_byte;
    item.eq    = &tap_ok;
    item.sp    = (in_byte == jkv_pkg::CH_SPACE) ||
                 (in_byte >= jkv_pkg::CH_TAB && in_byte <= jkv_pkg::CH_CR);
    item.q     = (in_byte == jkv_pkg::CH_QUOTE);
    item.colon = (in_byte == jkv_pkg::CH_COLON);
    item.bs    = (in_byte == jkv_pkg::CH_BSLASH);
    item.is_t  = (in_byte == jkv_pkg::CH_T);
    item.is_f  = (in_byte == jkv_pkg::CH_F);
    item.is_u  = (in_byte == jkv_pkg::CH_U);
    if (in_byte == jkv_pkg::CH_N) begin
      item.esc_d = jkv_pkg::CH_LF;
    end else if (in_byte == jkv_pkg::CH_T) begin
      item.esc_d = jkv_pkg::CH_TAB;
    end else if (in_byte == jkv_pkg::CH_R) begin
      item.esc_d = jkv_pkg::CH_CR;
    end else if (in_byte == jkv_pkg::CH_U) begin
      item.esc_d = jkv_pkg::CH_QMARK;
    end else begin
      item.esc_d = in_byte;
    end
  end

endmodule

@@ src/jkv_fifo.sv @@
module jkv_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jkv_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output jkv_pkg::item_t dout,
  output logic           empty
);

  localparam int PW = (jkv_pkg::QDEPTH > 1) ? $clog2(jkv_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(jkv_pkg::QDEPTH + 1);

  jkv_pkg::item_t ent_r [jkv_pkg::QDEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [CW-1:0]  cnt_r;

  assign full  = (cnt_r == CW'(jkv_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(jkv_pkg::QDEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(jkv_pkg::QDEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ src/jkv_back.sv @@
module jkv_back #(
  parameter int KEY_MAX = jkv_pkg::KEY_MAX_DEF,
  localparam int KLW = $clog2(KEY_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_v,
  input  jkv_pkg::item_t   it,
  output logic             pop,
  input  logic [KLW-1:0]   klen,
  input  jkv_pkg::bk_cfg_t cfg,
  output logic             out_v,
  input  logic             out_ready,
  output jkv_pkg::res_t    out_res
);

  localparam int SINCE_MAX = KEY_MAX + 15;
  localparam int SW = $clog2(SINCE_MAX + 1);

  typedef enum logic [7:0] {
    PH_SEARCH      = 8'b0000_0001,
    PH_AFTER_KEY   = 8'b0000_0010,
    PH_AFTER_COLON = 8'b0000_0100,
    PH_COPY        = 8'b0000_1000,
    PH_ESC         = 8'b0001_0000,
    PH_LITERAL     = 8'b0010_0000,
    PH_FAIL        = 8'b0100_0000,
    PH_OK          = 8'b1000_0000
  } phase_t;

  function automatic logic [7:0] lit_char(input logic is_false, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    if (is_false) begin
      unique case (p)
        3'd0:    ch = jkv_pkg::CH_F;
        3'd1:    ch = jkv_pkg::CH_A;
        3'd2:    ch = jkv_pkg::CH_L;
        3'd3:    ch = jkv_pkg::CH_S;
        3'd4:    ch = jkv_pkg::CH_E;
        default: ch = 8'h00;
      endcase
    end else begin
      unique case (p)
        3'd0:    ch = jkv_pkg::CH_T;
        3'd1:    ch = jkv_pkg::CH_R;
        3'd2:    ch = jkv_pkg::CH_U;
        3'd3:    ch = jkv_pkg::CH_E;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  phase_t        phase_r, phase_nxt;
  logic [SW-1:0] since_r, since_nxt, since_inc, plen;
  logic [15:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [2:0]    prog_r, prog_nxt, prog_inc, lit_len;
  logic          lf_r, lf_nxt;
  logic          match;
  logic [1:0]    nres;
  jkv_pkg::res_t r0, r1, st;
  jkv_pkg::res_t out_r, pend_r;
  logic          out_v_r, pend_v_r;
  logic          out_free, fire;

  always_comb begin
    phase_nxt = phase_r;
    since_nxt = since_r;
    cnt_nxt   = cnt_r;
    prog_nxt  = prog_r;
    lf_nxt    = lf_r;
    r0        = '0;
    r1        = '0;
    st        = '0;
    nres      = 2'd0;
    since_inc = (since_r < SW'(SINCE_MAX)) ? since_r + SW'(1) : since_r;
    plen      = SW'(klen) + SW'(2);
    match     = it.eq && (since_inc >= plen);
    cnt_inc   = cnt_r + 16'd1;
    prog_inc  = prog_r + 3'd1;
    lit_len   = lf_r ? 3'd5 : 3'd4;

    if (it.le) begin
      st.kind  = 1'b1;
      st.last  = 1'b1;
      st.found = (phase_r == PH_OK) || (phase_r == PH_COPY) || (phase_r == PH_ESC);
      st.bval  = (phase_r == PH_OK) && !lf_r;
      if (phase_r == PH_ESC) begin
        // dangling backslash goes out ahead of the status
        r0.data = jkv_pkg::CH_BSLASH;
        r1      = st;
        nres    = 2'd2;
      end else begin
        r0   = st;
        nres = 2'd1;
      end
      phase_nxt = PH_SEARCH;
      since_nxt = SW'(SINCE_MAX);
      cnt_nxt   = '0;
      prog_nxt  = '0;
      lf_nxt    = 1'b0;
    end else begin
      unique case (phase_r)
        PH_SEARCH: begin
          since_nxt = since_inc;
          if (match) begin
            phase_nxt = PH_AFTER_KEY;
            since_nxt = '0;
          end
        end
        PH_AFTER_KEY: begin
          since_nxt = since_inc;
          if (it.sp) begin
            phase_nxt = PH_AFTER_KEY;
          end else if (it.colon) begin
            phase_nxt = PH_AFTER_COLON;
          end else if (match) begin
            phase_nxt = PH_AFTER_KEY;
            since_nxt = '0;
          end else begin
            phase_nxt = PH_SEARCH;
          end
        end
        PH_AFTER_COLON: begin
          if (!it.sp) begin
            if (cfg.mode) begin
              if (it.is_t || it.is_f) begin
                phase_nxt = PH_LITERAL;
                lf_nxt    = it.is_f;
                prog_nxt  = 3'd1;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end else if (it.q) begin
              phase_nxt = PH_COPY;
              prog_nxt  = '0;
              if (cnt_r >= cfg.limit) begin
                phase_nxt = PH_OK;
                lf_nxt    = 1'b1;
              end
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
        end
        PH_COPY: begin
          if (prog_r != '0) begin
            prog_nxt = prog_r - 3'd1;
          end else if (cnt_r >= cfg.limit || it.q) begin
            phase_nxt = PH_OK;
            lf_nxt    = 1'b1;
          end else if (it.bs) begin
            phase_nxt = PH_ESC;
          end else begin
            r0.data = it.c;
            nres    = 2'd1;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= cfg.limit) begin
              phase_nxt = PH_OK;
              lf_nxt    = 1'b1;
            end
          end
        end
        PH_ESC: begin
          r0.data   = it.esc_d;
          nres      = 2'd1;
          cnt_nxt   = cnt_inc;
          phase_nxt = PH_COPY;
          prog_nxt  = it.is_u ? 3'd4 : 3'd0;
          if (cnt_inc >= cfg.limit) begin
            phase_nxt = PH_OK;
            lf_nxt    = 1'b1;
          end
        end
        PH_LITERAL: begin
          if (prog_r >= lit_len || it.c != lit_char(lf_r, prog_r)) begin
            phase_nxt = PH_FAIL;
          end else begin
            prog_nxt = prog_inc;
            if (prog_inc == lit_len) begin
              phase_nxt = PH_OK;
            end
          end
        end
        PH_FAIL, PH_OK: begin
          phase_nxt = phase_r;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // a held second result blocks the queue until it has moved to the output register
  assign out_free = !out_v_r || out_ready;
  assign fire     = item_v && !pend_v_r && (nres == 2'd0 || out_free);
  assign pop      = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      since_r <= SW'(SINCE_MAX);
      cnt_r   <= '0;
      prog_r  <= '0;
      lf_r    <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      since_r <= since_nxt;
      cnt_r   <= cnt_nxt;
      prog_r  <= prog_nxt;
      lf_r    <= lf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_v_r && out_free) begin
      out_r <= pend_r;
    end else if (fire && nres != 2'd0) begin
      out_r <= r0;
    end
    if (fire && nres == 2'd2) begin
      pend_r <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (pend_v_r) begin
        if (out_free) begin
          out_v_r  <= 1'b1;
          pend_v_r <= 1'b0;
        end
      end else if (fire && nres != 2'd0) begin
        out_v_r  <= 1'b1;
        pend_v_r <= (nres == 2'd2);
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_v   = out_v_r;
  assign out_res = out_r;

endmodule

@@ src/json_key_value_extractor.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_byte[7:0], in_line_end
// out       out_valid / out_ready  out_result_kind, out_data_byte[7:0], out_found,
//                                  out_bool_value, out_last
// cfg       cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[63:0]
//
// One byte per cycle sustained while out_ready is high and no second result is held: the
// back-end state machine retires one queued byte a cycle; its results are registered. A line
// end closing a pending escape gives two results and holds the back end until the second is registered.
// Stalls: a two-entry queue splits the classifier from the back end; out_ready low stalls
// only the back end until the queue fills. Reset is synchronous; cfg_ready is always high.
`include "json_key_value_extractor_defines.svh"

module json_key_value_extractor #(
  parameter int KEY_MAX = jkv_pkg::KEY_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_line_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_found,
  output logic        out_bool_value,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int KLW = $clog2(KEY_MAX + 1);

  logic [4:0]       key_length_r;
  logic [63:0]      key_lo_r, key_hi_r;
  logic             mode_r;
  logic [15:0]      cap_r;
  logic [KLW-1:0]   klen;
  jkv_pkg::bk_cfg_t bk_cfg;
  jkv_pkg::item_t   fr_item, q_item;
  jkv_pkg::res_t    res;
  logic             in_acc, q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= jkv_pkg::KEY_LENGTH_RST;
      key_lo_r     <= '0;
      key_hi_r     <= '0;
      mode_r       <= 1'b0;
      cap_r        <= jkv_pkg::CAPACITY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        jkv_pkg::REG_KEY_LENGTH: key_length_r <= cfg_data[4:0];
        jkv_pkg::REG_KEY_LOW:    key_lo_r     <= cfg_data;
        jkv_pkg::REG_KEY_HIGH:   key_hi_r     <= cfg_data;
        jkv_pkg::REG_MODE:       mode_r       <= cfg_data[0];
        jkv_pkg::REG_CAPACITY:   cap_r        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign klen = (int'(key_length_r) > KEY_MAX) ? KLW'(KEY_MAX) : KLW'(key_length_r);
  assign bk_cfg.mode  = mode_r;
  assign bk_cfg.limit = (cap_r == '0) ? 16'd0 : cap_r - 16'd1;

  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  jkv_front #(.KEY_MAX(KEY_MAX)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .in_byte  (in_byte),
    .line_end (in_line_end),
    .klen     (klen),
    .key_lo   (key_lo_r),
    .key_hi   (key_hi_r),
    .item     (fr_item)
  );

  jkv_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc),
    .din   (fr_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  jkv_back #(.KEY_MAX(KEY_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_v    (!q_empty),
    .it        (q_item),
    .pop       (q_pop),
    .klen      (klen),
    .cfg       (bk_cfg),
    .out_v     (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_result_kind = res.kind;
  assign out_data_byte   = res.data;
  assign out_found       = res.found;
  assign out_bool_value  = res.bval;
  assign out_last        = res.last;

  `JKV_ASSERT_NOW(a_last_is_status, out_valid && out_last, out_result_kind)
  `JKV_ASSERT_NOW(a_byte_has_no_status, out_valid && !out_result_kind,
                  !out_found && !out_bool_value && !out_last)
  `JKV_ASSERT_NOW(a_true_needs_found, out_valid && out_bool_value, out_found && out_last)
  `JKV_ASSERT_NEXT(a_reset_empties_out, !rst_n, !out_valid)

endmodule
